// ----- sv/mbrtu_pkg.sv -----
package mbrtu_pkg;

  localparam int TxBufSizeDef = 128;
  localparam int QueueAw = 2;

  localparam logic [1:0] ModeRequest = 2'd0;
  localparam logic [1:0] ModePayload = 2'd1;
  localparam logic [1:0] ModeRxByte  = 2'd2;
  localparam logic [1:0] ModeGap     = 2'd3;

  localparam logic [2:0] SelWriteMulti = 3'd6;
  localparam logic [7:0] FnReadCoils   = 8'h01;
  localparam logic [7:0] FnReadInput   = 8'h04;
  localparam logic [7:0] FnWriteMulti  = 8'h10;

  localparam logic [2:0] StAckSet  = 3'd0;
  localparam logic [2:0] StValid   = 3'd1;
  localparam logic [2:0] StShort   = 3'd2;
  localparam logic [2:0] StCrcErr  = 3'd3;
  localparam logic [2:0] StDropped = 3'd4;

  localparam logic [7:0] MinFrameLen  = 8'd4;
  localparam logic [7:0] AckFrameLen  = 8'd7;
  localparam logic [7:0] MaxByteCount = 8'd100;
  localparam logic [9:0] FrameOverhead = 10'd9;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // one command for the back end: header bytes, optional CRC tail, or a status
  typedef struct packed {
    logic [6:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            crc_init;
    logic            crc_tail;
    logic            verdict;
    logic [2:0]      status;
    logic [5:0]      ack;
  } cmd_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/mbrtu_if.sv -----
interface mbrtu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  slave_addr;
  logic [2:0]  function_sel;
  logic [15:0] start_reg;
  logic [15:0] count_or_value;
  logic [7:0]  data_byte;

  modport source (output valid, mode, slave_addr, function_sel, start_reg,
                  count_or_value, data_byte, input ready);
  modport sink (input valid, mode, slave_addr, function_sel, start_reg,
                count_or_value, data_byte, output ready);
endinterface

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       last;
  logic [2:0] status;
  logic [5:0] ack_flags;

  modport source (output valid, kind, tx_byte, last, status, ack_flags, input ready);
  modport sink (input valid, kind, tx_byte, last, status, ack_flags, output ready);
endinterface

// ----- sv/mbrtu_front.sv -----
module mbrtu_front #(
  parameter int TX_BUF_SIZE = mbrtu_pkg::TxBufSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mbrtu_in_if.sink           in_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output mbrtu_pkg::cmd_t    q_cmd_o
);

  localparam int PlW = $clog2(TX_BUF_SIZE);
  localparam logic [9:0] BufLen = 10'(TX_BUF_SIZE);

  logic [PlW-1:0] payload_left_q, payload_left_d;
  logic [7:0]     rx_count_q, rx_count_d;
  logic [15:0]    rx_crc_q, rx_crc_d;
  logic [7:0]     rx_function_q, rx_function_d;
  logic [7:0]     rx_byte_count_q, rx_byte_count_d;
  logic [5:0]     ack_q, ack_d;

  logic           accept;
  logic [7:0]     cnt;
  logic [9:0]     frame_len;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign cnt        = in_i.count_or_value[7:0];
  assign frame_len  = {1'b0, cnt, 1'b0} + mbrtu_pkg::FrameOverhead;

  always_comb begin
    payload_left_d  = payload_left_q;
    rx_count_d      = rx_count_q;
    rx_crc_d        = rx_crc_q;
    rx_function_d   = rx_function_q;
    rx_byte_count_d = rx_byte_count_q;
    ack_d           = ack_q;
    q_push_o        = 1'b0;
    q_cmd_o         = '0;

    unique case (in_i.mode)
      mbrtu_pkg::ModeRequest: begin
        if (in_i.function_sel < mbrtu_pkg::SelWriteMulti) begin
          payload_left_d   = '0;
          ack_d            = ack_q & ~(6'd1 << in_i.function_sel);
          q_push_o         = accept;
          q_cmd_o.bytes[0] = in_i.slave_addr;
          q_cmd_o.bytes[1] = {5'd0, in_i.function_sel} + 8'd1;
          q_cmd_o.bytes[2] = in_i.start_reg[15:8];
          q_cmd_o.bytes[3] = in_i.start_reg[7:0];
          q_cmd_o.bytes[4] = in_i.count_or_value[15:8];
          q_cmd_o.bytes[5] = in_i.count_or_value[7:0];
          q_cmd_o.nbytes   = 3'd6;
          q_cmd_o.crc_init = 1'b1;
          q_cmd_o.crc_tail = 1'b1;
        end else if (in_i.function_sel == mbrtu_pkg::SelWriteMulti) begin
          q_push_o = accept;
          if (frame_len > BufLen) begin
            payload_left_d = '0;
            q_cmd_o.verdict = 1'b1;
            q_cmd_o.status  = mbrtu_pkg::StDropped;
            q_cmd_o.ack     = ack_q;
          end else begin
            payload_left_d   = PlW'({cnt, 1'b0});
            q_cmd_o.bytes[0] = in_i.slave_addr;
            q_cmd_o.bytes[1] = mbrtu_pkg::FnWriteMulti;
            q_cmd_o.bytes[2] = in_i.start_reg[15:8];
            q_cmd_o.bytes[3] = in_i.start_reg[7:0];
            q_cmd_o.bytes[4] = 8'd0;
            q_cmd_o.bytes[5] = cnt;
            q_cmd_o.bytes[6] = {cnt[6:0], 1'b0};
            q_cmd_o.nbytes   = 3'd7;
            q_cmd_o.crc_init = 1'b1;
            q_cmd_o.crc_tail = (cnt == 8'd0);
          end
        end
      end
      mbrtu_pkg::ModePayload: begin
        if (payload_left_q != '0) begin
          payload_left_d   = payload_left_q - PlW'(1);
          q_push_o         = accept;
          q_cmd_o.bytes[0] = in_i.data_byte;
          q_cmd_o.nbytes   = 3'd1;
          q_cmd_o.crc_tail = (payload_left_q == PlW'(1));
        end
      end
      mbrtu_pkg::ModeRxByte: begin
        rx_crc_d = mbrtu_pkg::crc_feed(rx_crc_q, in_i.data_byte);
        if (rx_count_q == 8'd1) begin
          rx_function_d = in_i.data_byte;
        end else if (rx_count_q == 8'd2) begin
          rx_byte_count_d = in_i.data_byte;
        end
        if (rx_count_q != 8'hFF) begin
          rx_count_d = rx_count_q + 8'd1;
        end
      end
      mbrtu_pkg::ModeGap: begin
        q_push_o        = accept;
        q_cmd_o.verdict = 1'b1;
        if (rx_count_q < mbrtu_pkg::MinFrameLen) begin
          q_cmd_o.status = mbrtu_pkg::StShort;
        end else if (rx_crc_q != 16'd0) begin
          q_cmd_o.status = mbrtu_pkg::StCrcErr;
        end else if (rx_function_q == mbrtu_pkg::FnReadCoils &&
                     rx_count_q >= mbrtu_pkg::AckFrameLen) begin
          ack_d          = ack_q | 6'b000001;
          q_cmd_o.status = mbrtu_pkg::StAckSet;
        end else if (rx_function_q == mbrtu_pkg::FnReadInput &&
                     rx_byte_count_q <= mbrtu_pkg::MaxByteCount) begin
          ack_d          = ack_q | 6'b001000;
          q_cmd_o.status = mbrtu_pkg::StAckSet;
        end else begin
          q_cmd_o.status = mbrtu_pkg::StValid;
        end
        q_cmd_o.ack = ack_d;
        rx_count_d  = 8'd0;
        rx_crc_d    = mbrtu_pkg::CrcInit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_left_q  <= '0;
      rx_count_q      <= '0;
      rx_crc_q        <= mbrtu_pkg::CrcInit;
      rx_function_q   <= '0;
      rx_byte_count_q <= '0;
      ack_q           <= '0;
    end else if (accept) begin
      payload_left_q  <= payload_left_d;
      rx_count_q      <= rx_count_d;
      rx_crc_q        <= rx_crc_d;
      rx_function_q   <= rx_function_d;
      rx_byte_count_q <= rx_byte_count_d;
      ack_q           <= ack_d;
    end
  end

endmodule

// ----- sv/mbrtu_fifo.sv -----
module mbrtu_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbrtu_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mbrtu_pkg::cmd_t cmd_o
);

  localparam int Aw = mbrtu_pkg::QueueAw;

  mbrtu_pkg::cmd_t mem_q [2**Aw];
  mbrtu_pkg::cmd_t head_q;
  logic [Aw:0]     wr_q, rd_q, rd_d;

  assign full_o  = (wr_q[Aw] != rd_q[Aw]) && (wr_q[Aw-1:0] == rd_q[Aw-1:0]);
  assign valid_o = (wr_q != rd_q);
  assign cmd_o   = head_q;
  assign rd_d    = pop_i ? rd_q + (Aw+1)'(1) : rd_q;

  // head entry held in a register; a write into an emptying queue goes straight through
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[Aw-1:0]] <= cmd_i;
    end
    if (push_i && (wr_q == rd_d)) begin
      head_q <= cmd_i;
    end else begin
      head_q <= mem_q[rd_d[Aw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + (Aw+1)'(1);
      end
      rd_q <= rd_d;
    end
  end

endmodule

// ----- sv/mbrtu_back.sv -----
module mbrtu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mbrtu_pkg::cmd_t q_cmd_i,
  output logic            q_pop_o,
  mbrtu_out_if.source     out_o
);

  mbrtu_pkg::cmd_t cur_q;
  logic            cur_valid_q, cur_valid_d;
  logic [3:0]      idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;

  logic            out_valid_q, out_valid_d;
  logic            kind_q, last_q;
  logic [7:0]      byte_q;
  logic [2:0]      status_q;
  logic [5:0]      ack_q;

  logic            step, done, load;
  logic            r_kind, r_last;
  logic [7:0]      r_byte;
  logic [15:0]     crc_base;
  logic [3:0]      n_ext;

  assign step  = cur_valid_q && (!out_valid_q || out_o.ready);
  assign n_ext = {1'b0, cur_q.nbytes};

  always_comb begin
    r_kind   = 1'b0;
    r_last   = 1'b0;
    r_byte   = 8'd0;
    done     = 1'b0;
    crc_d    = crc_q;
    crc_base = (idx_q == 4'd0 && cur_q.crc_init) ? mbrtu_pkg::CrcInit : crc_q;
    if (cur_q.verdict) begin
      r_kind = 1'b1;
      done   = 1'b1;
    end else if (idx_q < n_ext) begin
      r_byte = cur_q.bytes[idx_q[2:0]];
      crc_d  = mbrtu_pkg::crc_feed(crc_base, r_byte);
      done   = (idx_q + 4'd1 == n_ext) && !cur_q.crc_tail;
    end else if (idx_q == n_ext) begin
      r_byte = crc_q[7:0];
    end else begin
      r_byte = crc_q[15:8];
      r_last = 1'b1;
      done   = 1'b1;
      crc_d  = mbrtu_pkg::CrcInit;
    end
  end

  assign load    = q_valid_i && (!cur_valid_q || (step && done));
  assign q_pop_o = load;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_valid_d = 1'b1;
      idx_d       = 4'd0;
    end else if (step) begin
      cur_valid_d = !done;
      idx_d       = idx_q + 4'd1;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      crc_q       <= mbrtu_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_cmd_i;
    end
    if (step) begin
      kind_q   <= r_kind;
      byte_q   <= r_byte;
      last_q   <= r_last;
      status_q <= r_kind ? cur_q.status : 3'd0;
      ack_q    <= r_kind ? cur_q.ack : 6'd0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = kind_q;
  assign out_o.tx_byte   = byte_q;
  assign out_o.last      = last_q;
  assign out_o.status    = status_q;
  assign out_o.ack_flags = ack_q;

`ifndef SYNTH
  a_tail_restarts_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && r_last |=> crc_q == mbrtu_pkg::CrcInit)
    else $error("tx crc not restarted after frame tail");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !cur_q.verdict |-> idx_q <= n_ext + 4'd1)
    else $error("byte index past end of command");

  a_last_is_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> !kind_q && status_q == 3'd0 && ack_q == 6'd0)
    else $error("last flag on a status result");

  a_no_load_mid_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !(step && done) |-> !load)
    else $error("command replaced before it finished");
`endif

endmodule

// ----- sv/modbus_rtu_master_framer_top.sv -----
// Path: an item passes the queue head register, the back end's command register and
//   the output register; a 4-entry command queue sits between front and back.
// Throughput: one item per cycle in while the queue is not full; one result per cycle out while
//   ready is high. Out: 01H..06H request 6 bytes + CRC, 10H header 7 (+ CRC if count 0), payload 1 (+ CRC on last).
// Reset: asynchronous, active low; clears counters, ack flags and queue, CRCs to FFFFH.
module modbus_rtu_master_framer_top #(
  parameter int TX_BUF_SIZE = mbrtu_pkg::TxBufSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrtu_in_if.sink    in_i,
  mbrtu_out_if.source out_o
);

  logic            push, full, pop, q_valid;
  mbrtu_pkg::cmd_t push_cmd, head_cmd;

  mbrtu_front #(
    .TX_BUF_SIZE(TX_BUF_SIZE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .q_push_o (push),
    .q_cmd_o  (push_cmd)
  );

  mbrtu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  mbrtu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule

// ----- tb/mbrtu_tb_pkg.sv -----
`timescale 1ns / 100ps
package mbrtu_tb_pkg;
  import mbrtu_pkg::*;

  localparam logic [2:0] SelReadCoils     = 3'd0;
  localparam logic [2:0] SelReadDiscrete  = 3'd1;
  localparam logic [2:0] SelReadHolding   = 3'd2;
  localparam logic [2:0] SelReadInput     = 3'd3;
  localparam logic [2:0] SelWriteCoil     = 3'd4;
  localparam logic [2:0] SelWriteReg      = 3'd5;
  localparam logic [2:0] SelUnused        = 3'd7;

  localparam int AckBitCoils = 0;
  localparam int AckBitInput = 3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  slave_addr;
    logic [2:0]  function_sel;
    logic [15:0] start_reg;
    logic [15:0] count_or_value;
    logic [7:0]  data_byte;
  } rtu_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [2:0] status;
    logic [5:0] ack_flags;
  } frame_res_t;

  // bit-serial form of the reflected CRC-16
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

endpackage

// ----- tb/mbrtu_checker.sv -----
`timescale 1ns / 100ps
module mbrtu_checker #(
  parameter int TX_BUF_SIZE = mbrtu_pkg::TxBufSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrtu_in_if         in_mon_i,
  mbrtu_out_if        out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import mbrtu_pkg::*;
  import mbrtu_tb_pkg::*;

  localparam int unsigned ReportMax = 10;

  logic [8:0]  payload_due;
  logic [15:0] tx_crc_acc;
  logic [7:0]  rx_len;
  logic [15:0] rx_crc_acc;
  logic [7:0]  rx_fn;
  logic [7:0]  rx_bc;
  logic [5:0]  acks;
  frame_res_t  frame_q[$];
  int unsigned n_fail;

  task automatic push_byte(input logic [7:0] b);
    tx_crc_acc = crc16_step(tx_crc_acc, b);
    frame_q.push_back('{kind: 1'b0, tx_byte: b, last: 1'b0, status: '0, ack_flags: '0});
  endtask

  task automatic push_crc();
    frame_q.push_back('{kind: 1'b0, tx_byte: tx_crc_acc[7:0], last: 1'b0,
                        status: '0, ack_flags: '0});
    frame_q.push_back('{kind: 1'b0, tx_byte: tx_crc_acc[15:8], last: 1'b1,
                        status: '0, ack_flags: '0});
    tx_crc_acc = CrcInit;
  endtask

  task automatic push_verdict(input logic [2:0] st);
    frame_q.push_back('{kind: 1'b1, tx_byte: '0, last: 1'b0, status: st, ack_flags: acks});
  endtask

  task automatic predict_item();
    logic [1:0]  mode;
    logic [7:0]  addr;
    logic [2:0]  sel;
    logic [15:0] sreg;
    logic [15:0] cv;
    logic [7:0]  db;
    logic [7:0]  cnt;
    logic [2:0]  st;
    mode = in_mon_i.mode;
    addr = in_mon_i.slave_addr;
    sel  = in_mon_i.function_sel;
    sreg = in_mon_i.start_reg;
    cv   = in_mon_i.count_or_value;
    db   = in_mon_i.data_byte;
    case (mode)
      ModeRequest: begin
        if (sel <= SelWriteReg) begin
          payload_due = '0;
          tx_crc_acc  = CrcInit;
          push_byte(addr);
          push_byte({5'd0, sel} + 8'd1);
          push_byte(sreg[15:8]);
          push_byte(sreg[7:0]);
          push_byte(cv[15:8]);
          push_byte(cv[7:0]);
          push_crc();
          acks[sel] = 1'b0;
        end else if (sel == SelWriteMulti) begin
          cnt = cv[7:0];
          if (int'(FrameOverhead) + 2 * int'(cnt) > TX_BUF_SIZE) begin
            payload_due = '0;
            push_verdict(StDropped);
          end else begin
            tx_crc_acc = CrcInit;
            push_byte(addr);
            push_byte(FnWriteMulti);
            push_byte(sreg[15:8]);
            push_byte(sreg[7:0]);
            push_byte(8'h00);
            push_byte(cnt);
            push_byte({cnt[6:0], 1'b0});
            payload_due = {cnt, 1'b0};
            if (payload_due == '0) begin
              push_crc();
            end
          end
        end
      end
      ModePayload: begin
        if (payload_due != '0) begin
          push_byte(db);
          payload_due = payload_due - 9'd1;
          if (payload_due == '0) begin
            push_crc();
          end
        end
      end
      ModeRxByte: begin
        rx_crc_acc = crc16_step(rx_crc_acc, db);
        if (rx_len == 8'd1) begin
          rx_fn = db;
        end else if (rx_len == 8'd2) begin
          rx_bc = db;
        end
        if (rx_len != 8'hFF) begin
          rx_len = rx_len + 8'd1;
        end
      end
      default: begin
        if (rx_len < MinFrameLen) begin
          st = StShort;
        end else if (rx_crc_acc != 16'h0000) begin
          st = StCrcErr;
        end else if (rx_fn == FnReadCoils && rx_len >= AckFrameLen) begin
          acks[AckBitCoils] = 1'b1;
          st = StAckSet;
        end else if (rx_fn == FnReadInput && rx_bc <= MaxByteCount) begin
          acks[AckBitInput] = 1'b1;
          st = StAckSet;
        end else begin
          st = StValid;
        end
        rx_len     = '0;
        rx_crc_acc = CrcInit;
        push_verdict(st);
      end
    endcase
  endtask

  task automatic check_result();
    frame_res_t got;
    frame_res_t want;
    got = '{kind: out_mon_i.kind, tx_byte: out_mon_i.tx_byte, last: out_mon_i.last,
            status: out_mon_i.status, ack_flags: out_mon_i.ack_flags};
    if (frame_q.size() == 0) begin
      n_fail++;
      if (n_fail <= ReportMax) begin
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0d status=%0d ack=%02h",
                 $realtime, got.kind, got.tx_byte, got.last, got.status, got.ack_flags);
      end
    end else begin
      want = frame_q.pop_front();
      if (got.kind != want.kind || got.tx_byte != want.tx_byte || got.last != want.last ||
          got.status != want.status || got.ack_flags != want.ack_flags) begin
        n_fail++;
        if (n_fail <= ReportMax) begin
          $display("%0t: mismatch exp kind=%0d byte=%02h last=%0d status=%0d ack=%02h",
                   $realtime, want.kind, want.tx_byte, want.last, want.status,
                   want.ack_flags);
          $display("%0t:          got kind=%0d byte=%02h last=%0d status=%0d ack=%02h",
                   $realtime, got.kind, got.tx_byte, got.last, got.status, got.ack_flags);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_due = '0;
      tx_crc_acc  = CrcInit;
      rx_len      = '0;
      rx_crc_acc  = CrcInit;
      rx_fn       = '0;
      rx_bc       = '0;
      acks        = '0;
      n_fail      = 0;
      frame_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_item();
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        check_result();
      end
      fail_count_o <= n_fail;
      pending_o    <= frame_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import mbrtu_pkg::*;
  import mbrtu_tb_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ItemsPerPhase = 70;
  localparam int unsigned DrainCycles   = 20;
  localparam int          MaxFitCnt     = (TxBufSizeDef - int'(FrameOverhead)) / 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  mbrtu_in_if  in_if ();
  mbrtu_out_if out_if ();

  modbus_rtu_master_framer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mbrtu_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic rtu_item_t random_item(input logic [1:0] mode);
    rtu_item_t it;
    it.mode           = mode;
    it.slave_addr     = 8'($urandom);
    it.function_sel   = 3'($urandom_range(7));
    it.start_reg      = 16'($urandom);
    it.count_or_value = 16'($urandom);
    it.data_byte      = 8'($urandom);
    return it;
  endfunction

  task automatic drive_item(input rtu_item_t it, input bit counted);
    int unsigned gap;
    in_if.valid          <= 1'b1;
    in_if.mode           <= it.mode;
    in_if.slave_addr     <= it.slave_addr;
    in_if.function_sel   <= it.function_sel;
    in_if.start_reg      <= it.start_reg;
    in_if.count_or_value <= it.count_or_value;
    in_if.data_byte      <= it.data_byte;
    do @(posedge clk_i); while (!in_if.ready);
    if (counted) begin
      items_sent++;
    end
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_request(input logic [2:0] sel, input logic [7:0] addr,
                              input logic [15:0] sreg, input logic [15:0] cv);
    rtu_item_t it;
    it = random_item(ModeRequest);
    it.function_sel   = sel;
    it.slave_addr     = addr;
    it.start_reg      = sreg;
    it.count_or_value = cv;
    drive_item(it, sel != SelUnused);
  endtask

  task automatic send_payload(input logic [7:0] b, input bit counted);
    rtu_item_t it;
    it = random_item(ModePayload);
    it.data_byte = b;
    drive_item(it, counted);
  endtask

  task automatic send_write_multi(input logic [7:0] cnt, input int unsigned n_pay);
    send_request(SelWriteMulti, 8'($urandom), 16'($urandom), {8'($urandom), cnt});
    repeat (n_pay) send_payload(8'($urandom), 1'b1);
  endtask

  task automatic send_rx(input logic [7:0] b);
    rtu_item_t it;
    it = random_item(ModeRxByte);
    it.data_byte = b;
    drive_item(it, 1'b1);
  endtask

  // short lengths give raw bytes only; otherwise a CRC-terminated frame
  task automatic send_rx_frame(input logic [7:0] fn, input logic [7:0] bc,
                               input int unsigned len, input bit corrupt);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    int unsigned pos;
    crc = CrcInit;
    if (len < MinFrameLen) begin
      repeat (len) fr.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < int'(len) - 2; i++) begin
        fr.push_back(i == 1 ? fn : (i == 2 ? bc : 8'($urandom)));
        crc = crc16_step(crc, fr[i]);
      end
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
      if (corrupt) begin
        pos = $urandom_range(len - 1);
        fr[pos] = fr[pos] ^ 8'(1 << $urandom_range(7));
      end
    end
    foreach (fr[i]) send_rx(fr[i]);
    drive_item(random_item(ModeGap), 1'b1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic directed();
    send_rx_frame(8'h00, 8'h00, 0, 1'b0);
    send_request(SelReadCoils, 8'h00, 16'h0000, 16'h0000);
    send_request(SelReadDiscrete, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(SelReadHolding, 8'hA5, 16'h00FF, 16'hFF00);
    send_request(SelReadInput, 8'h5A, 16'hFF00, 16'h00FF);
    send_request(SelWriteCoil, 8'h01, 16'h1234, 16'hFF00);
    send_request(SelWriteReg, 8'hF7, 16'hABCD, 16'h5432);
    send_request(SelUnused, 8'h11, 16'h1111, 16'h1111);
    send_request(SelWriteMulti, 8'h12, 16'h0010, 16'hFF00);
    send_request(SelWriteMulti, 8'h13, 16'h0001, 16'hFF01);
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(8'h3C, 1'b0);
    send_request(SelWriteMulti, 8'h22, 16'h0100, 16'(MaxFitCnt + 1));
    // header accepted, payload cut short by a fresh request
    send_request(SelWriteMulti, 8'h33, 16'h0002, 16'h0002);
    send_payload(8'h81, 1'b1);
    send_request(SelReadCoils, 8'h44, 16'h0003, 16'h0004);
    send_rx_frame(FnReadCoils, 8'h02, 7, 1'b0);
    send_rx_frame(FnReadInput, MaxByteCount, 5, 1'b0);
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned roll;
    int unsigned cnt;
    logic [7:0]  fn;
    logic [7:0]  bc;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_request(3'($urandom_range(SelWriteReg)), 8'($urandom), 16'($urandom),
                   16'($urandom));
    end else if (pick < 50) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        cnt = $urandom_range(255, MaxFitCnt + 1);
      end else if (roll < 13) begin
        cnt = $urandom_range(MaxFitCnt, 5);
      end else begin
        cnt = $urandom_range(4);
      end
      if (cnt > MaxFitCnt) begin
        send_write_multi(8'(cnt), 0);
      end else if (cnt != 0 && $urandom_range(99) < 15) begin
        send_write_multi(8'(cnt), $urandom_range(2 * cnt - 1));
        send_request(3'($urandom_range(SelWriteMulti)), 8'($urandom), 16'($urandom),
                     16'($urandom));
      end else begin
        send_write_multi(8'(cnt), 2 * cnt);
      end
    end else if (pick < 85) begin
      roll = $urandom_range(99);
      fn = (roll < 40) ? FnReadCoils : ((roll < 80) ? FnReadInput : 8'($urandom));
      bc = $urandom_range(1) ? 8'($urandom_range(110, 90)) : 8'($urandom);
      send_rx_frame(fn, bc, $urandom_range(12, 4), $urandom_range(99) < 15);
    end else if (pick < 93) begin
      send_rx_frame(8'h00, 8'h00, $urandom_range(3), 1'b0);
    end else if (pick < 97) begin
      if ($urandom_range(1)) begin
        send_payload(8'($urandom), 1'b0);
      end else begin
        send_request(SelUnused, 8'($urandom), 16'($urandom), 16'($urandom));
      end
    end else begin
      drive_item(random_item(2'($urandom_range(3))), 1'b1);
    end
  endtask

  initial begin
    int unsigned phase_end;
    in_if.valid          <= 1'b0;
    in_if.mode           <= ModeRequest;
    in_if.slave_addr     <= '0;
    in_if.function_sel   <= '0;
    in_if.start_reg      <= '0;
    in_if.count_or_value <= '0;
    in_if.data_byte      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 60;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 60;
        end
        default: begin
          idle_pct  = 20;
          stall_pct = 20;
        end
      endcase
      // receive count saturates past 255 bytes
      if (ph == 3) begin
        send_rx_frame(FnReadCoils, 8'($urandom), $urandom_range(262, 256), 1'b0);
      end
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end) random_sequence();
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
